// ===== rtl/lfid_pkg.sv =====
// Package for the lowest-free ID allocator: widths, codes and defaults.
`default_nettype none

package lfid_pkg;

    localparam int IDW = 11;
    localparam int OPW = 2;
    localparam int STW = 2;

    localparam int MAX_IDS_DEF       = 1024;
    localparam int MAP_WORD_BITS_DEF = 64;

    typedef enum logic [OPW-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_PRESET  = 2'd3
    } t_op;

    typedef enum logic [STW-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LIVE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLOT,
        S_READ,
        S_CALC
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/lfid_ram.sv =====
// Freed-ID bitmap memory: one write port, one registered read port.
`default_nettype none

module lfid_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lowest_free_id_allocator.sv =====
// Top level of the lowest-free ID allocator.
//
// Input channel (i_valid/o_ready) carries one command item: allocate, release,
// query or preset. Every item yields exactly one result item on the output
// channel (o_valid/i_ready): issued ID, fresh flag, query answer, status and
// the live count after the command.
// A configuration write (i_cfg_valid/o_cfg_ready) sets zero-based numbering;
// write it only while no item is in flight.
// An accepted item passes through slot computation, one read of the freed bitmap
// memory, then the modify and write-back step, which loads the output register.
// The input reopens the cycle after that step, so only one item is in flight at
// a time, as each item does a read-modify-write of the single bitmap memory.
// The result sits in an output register, so the next item is accepted while
// a result waits; if the receiver stalls, the following item waits in its
// final step until the output register frees.
// Synchronous active-low reset clears the count, high-water mark, summary bits
// and mode; the bitmap words need no clearing, the summary bits mask them.
`default_nettype none

module lowest_free_id_allocator #(
    parameter int MAX_IDS       = lfid_pkg::MAX_IDS_DEF,
    parameter int MAP_WORD_BITS = lfid_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic                     i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [lfid_pkg::OPW-1:0] i_op,
    input  wire logic [lfid_pkg::IDW-1:0] i_target_id,
    input  wire logic [lfid_pkg::IDW-1:0] i_preset_count,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [lfid_pkg::IDW-1:0]      o_issued_id,
    output logic                          o_fresh,
    output logic                          o_is_live,
    output logic [lfid_pkg::STW-1:0]      o_status,
    output logic [lfid_pkg::IDW-1:0]      o_live_count
);

    localparam int IDW    = lfid_pkg::IDW;
    localparam int W      = MAP_WORD_BITS;
    localparam int NWORDS = (MAX_IDS + W - 1) / W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW     = $clog2(W);
    localparam int CW     = $clog2(MAX_IDS + 1);
    localparam int SW     = (CW > IDW) ? CW : IDW;
    localparam int SLW    = $clog2(NWORDS * W);
    localparam int EW     = ((SW > SLW) ? SW : SLW) + 1;
    localparam int RK     = IDW + BW;
    localparam int RM     = ((1 << RK) + W - 1) / W;
    localparam int PW     = IDW + RK + 1;
    localparam int SUMW   = 1 << AW;

    lfid_pkg::t_state  r_state, n_state;
    lfid_pkg::t_op     r_op;
    logic [IDW-1:0]    r_tid;
    logic [IDW-1:0]    r_pc;
    logic              r_zb;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_mark;
    logic [SUMW-1:0]   r_summary;
    logic [AW-1:0]     r_word;
    logic [BW-1:0]     r_bit;
    logic              r_in_range;
    logic              r_hit;

    logic              r_out_valid;
    logic [IDW-1:0]    r_issued;
    logic              r_fresh;
    logic              r_live;
    lfid_pkg::t_status r_status;
    logic [IDW-1:0]    r_live_cnt;

    // slot stage
    logic              below;
    logic [IDW-1:0]    slot_s;
    logic [PW-1:0]     prod;
    logic [IDW-1:0]    quot;
    logic [IDW-1:0]    rem;
    logic              in_range;
    logic [AW-1:0]     low_w;
    logic              any_freed;

    // modify stage
    logic [W-1:0]      rdata;
    logic [W-1:0]      word_v;
    logic [BW-1:0]     low_b;
    logic [W-1:0]      bit_mask;
    logic              freed_bit;
    logic              live;
    logic              calc_fire;
    logic              mem_we;
    logic [W-1:0]      mem_wdata;
    logic [EW-1:0]     reuse_slot;
    logic [EW-1:0]     issue_ext;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     n_mark;
    logic [SUMW-1:0]   n_summary;
    logic              n_fresh;
    logic              n_live;
    lfid_pkg::t_status n_status;
    logic [SW-1:0]     pc_sat;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == lfid_pkg::S_IDLE);
    assign calc_fire   = (r_state == lfid_pkg::S_CALC) && (!r_out_valid || i_ready);

    always_comb begin
        below    = (r_tid == '0) && !r_zb;
        slot_s   = r_tid - IDW'(!r_zb);
        prod     = PW'(slot_s) * PW'(RM);
        quot     = IDW'(prod >> RK);
        rem      = slot_s - IDW'(quot * IDW'(W));
        in_range = !below && (SW'(slot_s) < SW'(r_mark)) && (SW'(slot_s) < SW'(MAX_IDS));
    end

    always_comb begin
        low_w = '0;
        for (int i = NWORDS - 1; i >= 0; i--) begin
            if (r_summary[i]) begin
                low_w = AW'(i);
            end
        end
        any_freed = |r_summary;
    end

    lfid_ram #(
        .DEPTH (NWORDS),
        .AW    (AW),
        .DW    (W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_word),
        .i_wdata (mem_wdata),
        .i_re    (r_state == lfid_pkg::S_READ),
        .i_raddr (r_word),
        .o_rdata (rdata)
    );

    always_comb begin
        word_v = r_summary[r_word] ? rdata : '0;
        low_b  = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (word_v[i]) begin
                low_b = BW'(i);
            end
        end
    end

    always_comb begin
        bit_mask   = '0;
        freed_bit  = 1'b0;
        live       = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = word_v;
        reuse_slot = '0;
        issue_ext  = '0;
        n_count    = r_count;
        n_mark     = r_mark;
        n_summary  = r_summary;
        n_fresh    = 1'b0;
        n_live     = 1'b0;
        n_status   = lfid_pkg::ST_OK;
        pc_sat     = SW'(r_pc);
        if (SW'(r_pc) > SW'(MAX_IDS)) begin
            pc_sat = SW'(MAX_IDS);
        end
        unique case (r_op)
            lfid_pkg::OP_ALLOC: begin
                bit_mask   = W'(1) << low_b;
                reuse_slot = EW'(r_word) * EW'(W) + EW'(low_b);
                if (r_hit) begin
                    mem_we              = calc_fire;
                    mem_wdata           = word_v & ~bit_mask;
                    n_summary[r_word]   = |(word_v & ~bit_mask);
                    n_count             = r_count + CW'(1);
                    issue_ext           = reuse_slot + EW'(!r_zb);
                end else if (SW'(r_mark) < SW'(MAX_IDS)) begin
                    issue_ext = EW'(r_mark) + EW'(!r_zb);
                    n_mark    = r_mark + CW'(1);
                    n_count   = r_count + CW'(1);
                    n_fresh   = 1'b1;
                end else begin
                    n_status = lfid_pkg::ST_FULL;
                end
            end
            lfid_pkg::OP_RELEASE: begin
                bit_mask  = W'(1) << r_bit;
                freed_bit = |(word_v & bit_mask);
                live      = r_in_range && !freed_bit;
                if (live) begin
                    mem_we            = calc_fire;
                    mem_wdata         = word_v | bit_mask;
                    n_summary[r_word] = 1'b1;
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    n_status = lfid_pkg::ST_NOT_LIVE;
                end
            end
            lfid_pkg::OP_QUERY: begin
                bit_mask  = W'(1) << r_bit;
                freed_bit = |(word_v & bit_mask);
                live      = r_in_range && !freed_bit;
                n_live    = live;
            end
            lfid_pkg::OP_PRESET: begin
                n_summary = '0;
                n_count   = CW'(pc_sat);
                n_mark    = CW'(pc_sat);
            end
            default: begin
                n_status = lfid_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfid_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = lfid_pkg::S_SLOT;
                end
            end
            lfid_pkg::S_SLOT: n_state = lfid_pkg::S_READ;
            lfid_pkg::S_READ: n_state = lfid_pkg::S_CALC;
            lfid_pkg::S_CALC: begin
                if (calc_fire) begin
                    n_state = lfid_pkg::S_IDLE;
                end
            end
            default: n_state = lfid_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zb        <= 1'b0;
            r_count     <= '0;
            r_mark      <= '0;
            r_summary   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_zb <= i_cfg_data;
            end
            if (calc_fire) begin
                r_count     <= n_count;
                r_mark      <= n_mark;
                r_summary   <= n_summary;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op  <= lfid_pkg::t_op'(i_op);
            r_tid <= i_target_id;
            r_pc  <= i_preset_count;
        end
        if (r_state == lfid_pkg::S_SLOT) begin
            r_word     <= (r_op == lfid_pkg::OP_ALLOC) ? low_w : AW'(quot);
            r_bit      <= rem[BW-1:0];
            r_in_range <= in_range;
            r_hit      <= any_freed;
        end
        if (calc_fire) begin
            r_issued   <= IDW'(issue_ext);
            r_fresh    <= n_fresh;
            r_live     <= n_live;
            r_status   <= n_status;
            r_live_cnt <= IDW'(SW'(n_count));
        end
    end

    assign o_valid      = r_out_valid;
    assign o_issued_id  = r_issued;
    assign o_fresh      = r_fresh;
    assign o_is_live    = r_live;
    assign o_status     = r_status;
    assign o_live_count = r_live_cnt;

endmodule

`default_nettype wire

// ===== rtl/lfid_chk.sv =====
// Port-level checker for the lowest-free ID allocator, bound to the top level.
`default_nettype none

module lfid_chk (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_valid,
    input wire logic [lfid_pkg::IDW-1:0] o_issued_id,
    input wire logic                     o_fresh,
    input wire logic                     o_is_live,
    input wire logic [lfid_pkg::STW-1:0] o_status
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == lfid_pkg::ST_FULL) |-> (o_issued_id == '0 && !o_fresh))
        else $error("pool full result carries an ID");

    a_not_live_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == lfid_pkg::ST_NOT_LIVE)
            |-> (o_issued_id == '0 && !o_fresh && !o_is_live))
        else $error("failed release carries other results");

    a_fresh_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fresh) |-> (o_status == lfid_pkg::ST_OK && !o_is_live))
        else $error("fresh ID with bad status or query answer");

    a_live_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_live) |-> (o_issued_id == '0 && o_status == lfid_pkg::ST_OK))
        else $error("query answer mixed with allocation");

endmodule

bind lowest_free_id_allocator lfid_chk u_lfid_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .o_issued_id (o_issued_id),
    .o_fresh     (o_fresh),
    .o_is_live   (o_is_live),
    .o_status    (o_status)
);

`default_nettype wire
